[rtl/core/ptc_pkg.sv]
// shared types, codes and helpers for the pressure/temperature compensation block
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int unsigned RAW_W   = 20;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // action codes
  localparam logic [1:0] ACT_TEMP  = 2'd0;
  localparam logic [1:0] ACT_PRESS = 2'd1;
  localparam logic [1:0] ACT_BOTH  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_9 = 2'd3;

  localparam logic [WORD_W-1:0] FINE_OFFSET = 32'd64000;
  localparam logic [WORD_W-1:0] RAW_FULL    = 32'd1048576;
  localparam logic [WORD_W-1:0] PRESS_SCALE = 32'd3125;
  localparam logic [WORD_W-1:0] DIV_BASE    = 32'd32768;
  localparam logic [WORD_W-1:0] ROUND_HALF  = 32'd128;
  localparam logic [WORD_W-1:0] TEMP_SCALE  = 32'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_MUL_A,
    ST_T_MUL_D,
    ST_T_MUL_T3,
    ST_T_FINE,
    ST_T_MUL_5,
    ST_T_SAT,
    ST_P_OFFSET,
    ST_P_MUL_QQ,
    ST_P_MUL_P6,
    ST_P_MUL_P5,
    ST_P_MUL_P3,
    ST_P_MUL_P2,
    ST_P_SUM_V1,
    ST_P_MUL_P1,
    ST_P_DIVISOR,
    ST_P_MUL_NUM,
    ST_DIV_SETUP,
    ST_DIV,
    ST_QUOT,
    ST_P_MUL_PP,
    ST_P_MUL_P9,
    ST_P_MUL_P8,
    ST_P_FINAL,
    ST_DONE
  } ptc_state_t;

  function automatic logic [WORD_W-1:0] asr32(input logic [WORD_W-1:0] x,
                                              input logic [4:0] n);
    asr32 = WORD_W'($signed(x) >>> n);
  endfunction

  function automatic logic [WORD_W-1:0] sext16(input logic [15:0] x);
    sext16 = {{16{x[15]}}, x};
  endfunction

endpackage

[rtl/core/pressure_temperature_compensation_top.sv]
// pressure/temperature compensation with a shared multiplier and serial divider
//
//  channel   | direction | handshake               | payload
//  s_axis    | in        | s_axis_tvalid/tready    | tdata raw_temp, raw_press; tuser action
//  m_axis    | out       | m_axis_tvalid/tready    | tdata temp_centi, press_pa; tuser flags
//  cfg       | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// a zero divisor ends pressure before the divide, with press_valid low; an unused action goes straight to done;
// the single 32x32 multiplier serves every multiply step and the one-bit-a-cycle divider takes 32 steps
// one item is in flight at a time; s_axis_tready is high only while idle
// the result register lets a new item start while the last result waits on m_axis_tready
// rst is synchronous and clears coefficients, the fine temperature, the state and m_axis_tvalid
`timescale 1ns / 1ps

module pressure_temperature_compensation_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ptc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // raw_temp[19:0], raw_press[39:20]
  input  logic [1:0]                        s_axis_tuser,  // action[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ptc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // temp_centi[15:0], press_pa[47:16]
  output logic [1:0]                        m_axis_tuser,  // temp_valid[0], press_valid[1]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import ptc_pkg::*;

  ptc_state_t state, state_next;

  logic [47:0]       temp_coeffs;
  logic [63:0]       press_coeffs_a;
  logic [63:0]       press_coeffs_b;
  logic [15:0]       press_coeff_nine;
  logic [WORD_W-1:0] fine_temp;

  logic [RAW_W-1:0]  raw_t;
  logic [RAW_W-1:0]  raw_p;
  logic [1:0]        act;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] v1;
  logic [WORD_W-1:0] q;
  logic [WORD_W-1:0] qq;
  logic [WORD_W-1:0] v2;
  logic [WORD_W-1:0] divisor;
  logic [WORD_W-1:0] press;
  logic              dbl;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvd;
  logic [4:0]        cnt;

  logic [15:0]       res_tc;
  logic              res_tv;
  logic [WORD_W-1:0] res_pa;
  logic              res_pv;

  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [WORD_W-1:0] mul_lo;
  logic              accept;
  logic              out_free;

  logic [WORD_W-1:0] t1, t2, t3;
  logic [WORD_W-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [WORD_W-1:0] v1_calc;
  logic [WORD_W-1:0] div_calc;
  logic [WORD_W-1:0] temp_calc;
  logic [15:0]       temp_sat;
  logic [WORD_W:0]   rem_sh;
  logic              rem_ge;

  assign t1 = {16'b0, temp_coeffs[15:0]};
  assign t2 = sext16(temp_coeffs[31:16]);
  assign t3 = sext16(temp_coeffs[47:32]);
  assign p1 = {16'b0, press_coeffs_a[15:0]};
  assign p2 = sext16(press_coeffs_a[31:16]);
  assign p3 = sext16(press_coeffs_a[47:32]);
  assign p4 = sext16(press_coeffs_a[63:48]);
  assign p5 = sext16(press_coeffs_b[15:0]);
  assign p6 = sext16(press_coeffs_b[31:16]);
  assign p7 = sext16(press_coeffs_b[47:32]);
  assign p8 = sext16(press_coeffs_b[63:48]);
  assign p9 = sext16(press_coeff_nine);

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  assign mul_lo   = WORD_W'(mul_a * mul_b);
  assign v1_calc  = asr32(fine_temp, 5'd1) - FINE_OFFSET;
  assign div_calc = asr32(prod, 5'd15);
  assign temp_calc = asr32(prod + ROUND_HALF, 5'd8);

  always_comb begin
    if ($signed(temp_calc) > 32'sd32767) begin
      temp_sat = 16'h7fff;
    end else if ($signed(temp_calc) < -32'sd32768) begin
      temp_sat = 16'h8000;
    end else begin
      temp_sat = temp_calc[15:0];
    end
  end

  // restoring divide step, one quotient bit a cycle
  assign rem_sh = {rem, dvd[WORD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (s_axis_tuser == ACT_TEMP || s_axis_tuser == ACT_BOTH) begin
            state_next = ST_T_MUL_A;
          end else if (s_axis_tuser == ACT_PRESS) begin
            state_next = ST_P_OFFSET;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_T_MUL_A:   state_next = ST_T_MUL_D;
      ST_T_MUL_D:   state_next = ST_T_MUL_T3;
      ST_T_MUL_T3:  state_next = ST_T_FINE;
      ST_T_FINE:    state_next = ST_T_MUL_5;
      ST_T_MUL_5:   state_next = ST_T_SAT;
      ST_T_SAT:     state_next = (act == ACT_BOTH) ? ST_P_OFFSET : ST_DONE;
      ST_P_OFFSET:  state_next = ST_P_MUL_QQ;
      ST_P_MUL_QQ:  state_next = ST_P_MUL_P6;
      ST_P_MUL_P6:  state_next = ST_P_MUL_P5;
      ST_P_MUL_P5:  state_next = ST_P_MUL_P3;
      ST_P_MUL_P3:  state_next = ST_P_MUL_P2;
      ST_P_MUL_P2:  state_next = ST_P_SUM_V1;
      ST_P_SUM_V1:  state_next = ST_P_MUL_P1;
      ST_P_MUL_P1:  state_next = ST_P_DIVISOR;
      ST_P_DIVISOR: state_next = (div_calc == '0) ? ST_DONE : ST_P_MUL_NUM;
      ST_P_MUL_NUM: state_next = ST_DIV_SETUP;
      ST_DIV_SETUP: state_next = ST_DIV;
      ST_DIV:       state_next = (cnt == '0) ? ST_QUOT : ST_DIV;
      ST_QUOT:      state_next = ST_P_MUL_PP;
      ST_P_MUL_PP:  state_next = ST_P_MUL_P9;
      ST_P_MUL_P9:  state_next = ST_P_MUL_P8;
      ST_P_MUL_P8:  state_next = ST_P_FINAL;
      ST_P_FINAL:   state_next = ST_DONE;
      ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // shared multiplier operands and handshake
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    s_axis_tready = (state == ST_IDLE);
    unique case (state)
      ST_T_MUL_A: begin
        mul_a = {15'b0, raw_t[19:3]} - {15'b0, t1[15:0], 1'b0};
        mul_b = t2;
      end
      ST_T_MUL_D: begin
        mul_a = {16'b0, raw_t[19:4]} - t1;
        mul_b = {16'b0, raw_t[19:4]} - t1;
      end
      ST_T_MUL_T3: begin
        mul_a = asr32(prod, 5'd12);
        mul_b = t3;
      end
      ST_T_MUL_5: begin
        mul_a = fine_temp;
        mul_b = TEMP_SCALE;
      end
      ST_P_MUL_QQ: begin
        mul_a = q;
        mul_b = q;
      end
      ST_P_MUL_P6: begin
        mul_a = asr32(prod, 5'd11);
        mul_b = p6;
      end
      ST_P_MUL_P5: begin
        mul_a = v1;
        mul_b = p5;
      end
      ST_P_MUL_P3: begin
        mul_a = p3;
        mul_b = asr32(qq, 5'd13);
      end
      ST_P_MUL_P2: begin
        mul_a = p2;
        mul_b = v1;
      end
      ST_P_MUL_P1: begin
        mul_a = DIV_BASE + v1;
        mul_b = p1;
      end
      ST_P_MUL_NUM: begin
        mul_a = (RAW_FULL - {12'b0, raw_p}) - asr32(v2, 5'd12);
        mul_b = PRESS_SCALE;
      end
      ST_P_MUL_PP: begin
        mul_a = {3'b0, press[31:3]};
        mul_b = {3'b0, press[31:3]};
      end
      ST_P_MUL_P9: begin
        mul_a = p9;
        mul_b = {13'b0, prod[31:13]};
      end
      ST_P_MUL_P8: begin
        mul_a = {2'b0, press[31:2]};
        mul_b = p8;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_axis_tvalid    <= 1'b0;
      fine_temp        <= '0;
      temp_coeffs      <= '0;
      press_coeffs_a   <= '0;
      press_coeffs_b   <= '0;
      press_coeff_nine <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TEMP:    temp_coeffs      <= cfg_data[47:0];
          CFG_PRESS_A: press_coeffs_a   <= cfg_data;
          CFG_PRESS_B: press_coeffs_b   <= cfg_data;
          CFG_PRESS_9: press_coeff_nine <= cfg_data[15:0];
          default:     temp_coeffs      <= temp_coeffs;
        endcase
      end

      if (state == ST_T_FINE) begin
        fine_temp <= acc + asr32(prod, 5'd14);
      end

      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_lo;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          raw_t  <= s_axis_tdata[19:0];
          raw_p  <= s_axis_tdata[39:20];
          act    <= s_axis_tuser;
          res_tc <= '0;
          res_tv <= 1'b0;
          res_pa <= '0;
          res_pv <= 1'b0;
        end
      end
      ST_T_MUL_D:   acc <= asr32(prod, 5'd11);
      ST_T_SAT: begin
        res_tc <= temp_sat;
        res_tv <= 1'b1;
      end
      ST_P_OFFSET: begin
        v1 <= v1_calc;
        q  <= asr32(v1_calc, 5'd2);
      end
      ST_P_MUL_P6:  qq <= prod;
      ST_P_MUL_P5:  v2 <= prod;
      ST_P_MUL_P3:  v2 <= asr32(v2 + {prod[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'b0};
      ST_P_MUL_P2:  acc <= asr32(prod, 5'd3);
      ST_P_SUM_V1:  v1 <= asr32(acc + asr32(prod, 5'd1), 5'd18);
      ST_P_DIVISOR: divisor <= div_calc;
      ST_DIV_SETUP: begin
        // large numerators are divided first and doubled afterward
        dbl <= prod[31];
        dvd <= prod[31] ? prod : {prod[30:0], 1'b0};
        rem <= '0;
        cnt <= '1;
      end
      ST_DIV: begin
        rem <= rem_ge ? WORD_W'(rem_sh - {1'b0, divisor}) : rem_sh[WORD_W-1:0];
        dvd <= {dvd[WORD_W-2:0], rem_ge};
        cnt <= cnt - 5'd1;
      end
      ST_QUOT:      press <= dbl ? {dvd[30:0], 1'b0} : dvd;
      ST_P_MUL_P8:  acc <= asr32(prod, 5'd12);
      ST_P_FINAL: begin
        res_pa <= press + asr32(acc + asr32(prod, 5'd13) + p7, 5'd4);
        res_pv <= 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          m_axis_tdata <= {res_pa, res_tc};
          m_axis_tuser <= {res_pv, res_tv};
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state != ST_IDLE)
    else $error("accepted item did not start work");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> divisor != '0)
    else $error("divide running with zero divisor");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && cnt == '0 |=> state == ST_QUOT)
    else $error("divide did not end after last step");

  a_temp_cleared: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == '0)
    else $error("temperature not zero when not valid");

  a_press_cleared: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[47:16] == '0)
    else $error("pressure not zero when not valid");
`endif

endmodule
